FILE: src/bpc_pkg.sv
package bpc_pkg;

  localparam int unsigned TimeBits = 16;
  localparam int unsigned DtBits   = 16;
  localparam int unsigned CmpBits  = ((TimeBits > DtBits) ? TimeBits : DtBits) + 1;

  localparam logic [CmpBits-1:0] TimeMaxW =
      {{(CmpBits - TimeBits){1'b0}}, {TimeBits{1'b1}}};

  localparam logic [15:0] ShortThreshRst = 16'd100;
  localparam logic [15:0] HoldThreshRst  = 16'd900;
  localparam logic [14:0] LockDurRst     = 15'd600;

  typedef enum logic [1:0] {
    ActSample = 2'd0,
    ActRead   = 2'd1,
    ActLock   = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StIdle    = 2'd0,
    StPressed = 2'd1,
    StShort   = 2'd2,
    StHold    = 2'd3
  } btn_state_e;

  typedef enum logic [1:0] {
    RegShortThresh = 2'd0,
    RegHoldThresh  = 2'd1,
    RegLockDur     = 2'd2,
    RegUnused      = 2'd3
  } cfg_reg_e;

endpackage

FILE: src/button_press_classifier_core.sv
// Classifies a push button from periodic samples and answers status reads, one transaction
// per cycle while no result is stalled: each accepted input gives exactly one result in the
// cycle after it is accepted. A new input is taken in the same cycle in which the waiting
// result leaves, so the input waits only while a result is stalled at the output; the state
// update is combinational logic between the input and the result register. tuser carries
// the action (sample, read, force lock, none); a sample carries the pressed level and the
// milliseconds since the previous sample. A read returns the status before it is cleared;
// reading a short or hold event consumes it and starts a lockout of lock_duration ms,
// during which samples only count the lockout down and the status stays idle. Thresholds and
// lockout length are written through the configuration channel, which is always ready.
module button_press_classifier_core
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [0] pressed, [16:1] elapsed_ms, [23:17] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [1:0] status, [2] locked, [7:3] zero
);

  logic [15:0] short_thresh_q;
  logic [15:0] hold_thresh_q;
  logic [14:0] lock_dur_q;

  btn_state_e          status_q, status_d;
  logic [TimeBits-1:0] press_time_q, press_time_d;
  logic [TimeBits-1:0] lock_rem_q, lock_rem_d;

  logic        out_valid_q;
  btn_state_e  out_status_q, out_status_d;
  logic        out_locked_q;

  logic in_fire;
  action_e act;
  logic pressed;
  logic [CmpBits-1:0] dt_w, lock_w, press_w, sum_w, sat_sum_w, lock_load_w;
  logic [CmpBits-1:0] short_w, hold_w;
  logic [TimeBits-1:0] lock_load;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign act     = action_e'(s_axis_tuser_i);
  assign pressed = s_axis_tdata_i[0];
  assign dt_w    = CmpBits'(s_axis_tdata_i[16:1]);
  assign lock_w  = CmpBits'(lock_rem_q);
  assign press_w = CmpBits'(press_time_q);
  assign short_w = CmpBits'(short_thresh_q);
  assign hold_w  = CmpBits'(hold_thresh_q);

  assign sum_w       = press_w + dt_w;
  assign sat_sum_w   = (sum_w > TimeMaxW) ? TimeMaxW : sum_w;
  assign lock_load_w = CmpBits'(lock_dur_q);
  assign lock_load   = (lock_load_w > TimeMaxW) ? TimeMaxW[TimeBits-1:0]
                                                : lock_load_w[TimeBits-1:0];

  always_comb begin
    status_d     = status_q;
    press_time_d = press_time_q;
    lock_rem_d   = lock_rem_q;
    out_status_d = status_q;
    unique case (act)
      ActSample: begin
        if (lock_rem_q != '0) begin
          status_d   = StIdle;
          lock_rem_d = (dt_w >= lock_w) ? '0 : lock_rem_q - dt_w[TimeBits-1:0];
        end else if (!pressed) begin
          if (status_q == StPressed) begin
            status_d = (press_w > short_w) ? StShort : StIdle;
          end
          press_time_d = '0;
        end else begin
          if (status_q == StIdle) begin
            press_time_d = sat_sum_w[TimeBits-1:0];
            status_d     = StPressed;
          end else if (status_q == StPressed) begin
            press_time_d = sat_sum_w[TimeBits-1:0];
            if (sat_sum_w > hold_w) begin
              status_d = StHold;
            end
          end
        end
        out_status_d = status_d;
      end
      ActRead: begin
        if (status_q == StShort || status_q == StHold) begin
          status_d     = StIdle;
          press_time_d = '0;
          lock_rem_d   = lock_load;
        end
      end
      ActLock: begin
        status_d     = StIdle;
        press_time_d = '0;
        lock_rem_d   = lock_load;
        out_status_d = StIdle;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_thresh_q <= ShortThreshRst;
      hold_thresh_q  <= HoldThreshRst;
      lock_dur_q     <= LockDurRst;
      status_q       <= StIdle;
      press_time_q   <= '0;
      lock_rem_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_addr_i))
          RegShortThresh: short_thresh_q <= cfg_data_i;
          RegHoldThresh:  hold_thresh_q  <= cfg_data_i;
          RegLockDur:     lock_dur_q     <= cfg_data_i[14:0];
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        status_q     <= status_d;
        press_time_q <= press_time_d;
        lock_rem_q   <= lock_rem_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_status_q <= StIdle;
      out_locked_q <= 1'b0;
    end else if (in_fire) begin
      out_status_q <= out_status_d;
      out_locked_q <= (lock_rem_d != '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_locked_q, out_status_q};

`ifndef NO_ASSERTIONS
  a_lock_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lock_rem_q != '0) |-> (status_q == StIdle && press_time_q == '0))
    else $error("lockout active with non-idle status or running press timer");

  a_force_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && act == ActLock) |=>
      (m_axis_tdata_o[1:0] == StIdle && m_axis_tdata_o[2] == (lock_dur_q != '0)))
    else $error("forced lock result does not match lockout length");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid_o)
    else $error("accepted transaction produced no result");
`endif

endmodule

FILE: tb/button_press_classifier_core_tb.sv
module button_press_classifier_core_tb;
  import bpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    btn_state_e  st;
    logic        locked;
  } key_result_t;

  typedef struct packed {
    action_e     act;
    logic        lvl;
    logic [15:0] ms;
    logic        typed;
    btn_state_e  st;
    logic        locked;
  } dir_row_t;

  localparam int unsigned NumDir = 25;

  localparam dir_row_t DirTab [NumDir] = '{
    '{ActSample, 1'b0, 16'd0,     1'b1, StIdle,    1'b0},
    '{ActRead,   1'b0, 16'd0,     1'b1, StIdle,    1'b0},
    '{ActNone,   1'b1, 16'hFFFF,  1'b1, StIdle,    1'b0},
    '{ActLock,   1'b1, 16'hFFFF,  1'b1, StIdle,    1'b1},
    '{ActSample, 1'b1, 16'd599,   1'b1, StIdle,    1'b1},
    '{ActSample, 1'b1, 16'd1,     1'b1, StIdle,    1'b0},
    '{ActSample, 1'b1, 16'hFFFF,  1'b1, StPressed, 1'b0},
    '{ActSample, 1'b1, 16'hFFFF,  1'b1, StHold,    1'b0},
    '{ActSample, 1'b1, 16'd5,     1'b0, StIdle,    1'b0},
    '{ActSample, 1'b0, 16'd0,     1'b0, StIdle,    1'b0},
    '{ActRead,   1'b1, 16'hFFFF,  1'b1, StHold,    1'b1},
    '{ActRead,   1'b0, 16'd0,     1'b0, StIdle,    1'b0},
    '{ActSample, 1'b1, 16'h8000,  1'b1, StIdle,    1'b0},
    '{ActSample, 1'b1, 16'd100,   1'b0, StIdle,    1'b0},
    '{ActSample, 1'b0, 16'd0,     1'b0, StIdle,    1'b0},
    '{ActSample, 1'b1, 16'd101,   1'b0, StIdle,    1'b0},
    '{ActSample, 1'b0, 16'd3,     1'b0, StIdle,    1'b0},
    '{ActSample, 1'b1, 16'd40,    1'b0, StIdle,    1'b0},
    '{ActRead,   1'b0, 16'd0,     1'b0, StIdle,    1'b0},
    '{ActSample, 1'b1, 16'd0,     1'b0, StIdle,    1'b0},
    '{ActLock,   1'b0, 16'd0,     1'b0, StIdle,    1'b0},
    '{ActSample, 1'b1, 16'd600,   1'b0, StIdle,    1'b0},
    '{ActSample, 1'b1, 16'd900,   1'b0, StIdle,    1'b0},
    '{ActSample, 1'b1, 16'd0,     1'b0, StIdle,    1'b0},
    '{ActSample, 1'b1, 16'd1,     1'b0, StIdle,    1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;

  logic [15:0] short_ms;
  logic [15:0] hold_ms;
  logic [14:0] lockout_ms;
  btn_state_e  btn_status;
  logic [15:0] press_ms;
  logic [15:0] lock_left;

  key_result_t pending_status [$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned tx_quiet;
  int unsigned rx_quiet;
  int unsigned rx_stall;
  logic        calm;

  button_press_classifier_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_addr_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

  function automatic void start_lockout();
    btn_status = StIdle;
    press_ms   = '0;
    lock_left  = {1'b0, lockout_ms};
  endfunction

  function automatic key_result_t classify(input action_e act, input logic lvl,
                                           input logic [15:0] ms);
    key_result_t res;
    logic [16:0] sum;
    res.st = btn_status;
    case (act)
      ActSample: begin
        if (lock_left != 0) begin
          btn_status = StIdle;
          lock_left  = (ms >= lock_left) ? 16'd0 : lock_left - ms;
        end else if (!lvl) begin
          if (btn_status == StPressed) begin
            btn_status = (press_ms > short_ms) ? StShort : StIdle;
          end
          press_ms = '0;
        end else begin
          if (btn_status == StPressed || btn_status == StIdle) begin
            sum      = {1'b0, press_ms} + {1'b0, ms};
            press_ms = sum[16] ? 16'hFFFF : sum[15:0];
          end
          if (btn_status == StIdle) begin
            btn_status = StPressed;
          end else if (btn_status == StPressed && press_ms > hold_ms) begin
            btn_status = StHold;
          end
        end
        res.st = btn_status;
      end
      ActRead: begin
        if (btn_status == StShort || btn_status == StHold) begin
          start_lockout();
        end
      end
      ActLock: begin
        start_lockout();
        res.st = btn_status;
      end
      default: ;
    endcase
    res.locked = (lock_left != 0);
    return res;
  endfunction

  function automatic logic [15:0] pick_ms();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return 16'($urandom_range(0, 120));
    end else if (r < 9) begin
      return 16'($urandom_range(0, 400));
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_item(input action_e act, input logic lvl, input logic [15:0] ms,
                           input logic typed = 1'b0, input key_result_t typed_res = '0);
    key_result_t res;
    if (tx_quiet != 0) begin
      tx_quiet--;
    end else if ($urandom_range(0, 39) == 0) begin
      tx_quiet = $urandom_range(30, 150);
    end
    if (!calm && tx_quiet == 0 && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, ms, lvl};
    s_axis_tuser_i  <= act;
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
    res = classify(act, lvl, ms);
    pending_status.push_back(typed ? typed_res : res);
    if (act != ActNone) begin
      items_sent++;
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    case (idx)
      RegShortThresh: short_ms   = val;
      RegHoldThresh:  hold_ms    = val;
      RegLockDur:     lockout_ms = val[14:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] sh, input logic [15:0] ho,
                           input logic [14:0] lk);
    settle();
    write_reg(RegShortThresh, sh);
    write_reg(RegHoldThresh, ho);
    write_reg(RegLockDur, {1'b0, lk});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned presses;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          presses = $urandom_range(1, 8);
          repeat (presses) send_item(ActSample, 1'b1, pick_ms());
          send_item(ActSample, 1'b0, pick_ms());
          if ($urandom_range(0, 3) != 0) begin
            send_item(ActRead, 1'($urandom), 16'($urandom));
          end
        end
        6: send_item(ActRead, 1'($urandom), 16'($urandom));
        7: send_item(ActLock, 1'($urandom), 16'($urandom));
        8: send_item(ActNone, 1'($urandom), 16'($urandom));
        default: send_item(ActSample, 1'($urandom), 16'($urandom));
      endcase
    end
  endtask

  initial begin
    rx_quiet        = 0;
    rx_stall        = 0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_quiet != 0) begin
        rx_quiet--;
      end else if ($urandom_range(0, 99) == 0) begin
        rx_quiet = $urandom_range(50, 200);
      end
      if (rx_stall != 0) begin
        rx_stall--;
        m_axis_tready_i <= 1'b0;
      end else if (!calm && rx_quiet == 0 && $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(0, 13);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin : result_check
    key_result_t want;
    btn_state_e  got_st;
    logic        got_locked;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_st     = btn_state_e'(m_axis_tdata_o[1:0]);
      got_locked = m_axis_tdata_o[2];
      if (pending_status.size() == 0) begin
        $error("Unexpected result: status %0d, locked %0b", got_st, got_locked);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        if (got_st != want.st) begin
          $error("status: expected %0d, actual %0d", want.st, got_st);
          mismatches++;
        end
        if (got_locked != want.locked) begin
          $error("locked: expected %0b, actual %0b", want.locked, got_locked);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_addr_i      = RegShortThresh;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = ActSample;
    mismatches      = 0;
    items_sent      = 0;
    tx_quiet        = 0;
    calm            = 1'b0;
    short_ms        = ShortThreshRst;
    hold_ms         = HoldThreshRst;
    lockout_ms      = LockDurRst;
    btn_status      = StIdle;
    press_ms        = '0;
    lock_left       = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDir; i++) begin
      send_item(DirTab[i].act, DirTab[i].lvl, DirTab[i].ms, DirTab[i].typed,
                '{DirTab[i].st, DirTab[i].locked});
    end
    random_traffic(300);

    configure(16'd0, 16'd0, 15'd0);
    write_reg(RegUnused, 16'($urandom));
    cfg_valid_i <= 1'b0;
    random_traffic(350);

    configure(16'hFFFF, 16'hFFFF, 15'h7FFF);
    random_traffic(350);

    configure(16'($urandom_range(0, 300)), 16'($urandom_range(0, 1800)),
              15'($urandom_range(0, 1500)));
    random_traffic(500);

    configure(16'd50, 16'd300, 15'd200);
    calm = 1'b1;
    random_traffic(500);

    settle();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
